// ===== hw/rtl/gsbhd_pkg.sv =====
package gsbhd_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
  localparam int WEIGHT_BITS  = 16;
  localparam int LEVEL_BITS   = VERTEX_BITS + 1;
  localparam int EDGE_BITS    = 2 * VERTEX_BITS;
  localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;

  localparam logic signed [15:0] ANSWER_NONE = -16'sd1;

  typedef enum logic [2:0] {
    CMD_ADD_VERTEX = 3'd0,
    CMD_ADD_EDGE   = 3'd1,
    CMD_VERTEX_Q   = 3'd2,
    CMD_EDGE_Q     = 3'd3,
    CMD_HOP_Q      = 3'd4
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t          cmd;
    logic [5:0]         src_vertex;
    logic [5:0]         dst_vertex;
    logic signed [15:0] weight_in;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] answer;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_WREAD,
    ST_SCAN,
    ST_DRAIN,
    ST_LEVEL,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/graph_store_bfs_hop_distance.sv =====
// command paths: add vertex in ST_IDLE, add edge through ST_ROW, vertex query through ST_RESP,
//   edge query through ST_ROW, ST_WREAD when found and ST_RESP, hop query a scan of all rows per bfs level
// throughput: one command at a time; the hop walk reads one adjacency row per
//   cycle from the single read port of the adjacency memory
// reset: vertex bits and per-row valid bits clear directly, no sweep;
//   the edge weight memory is not cleared and is read only for stored edges
module graph_store_bfs_hop_distance
  import gsbhd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  // latched command beat
  cmd_code_t          cmd_q;
  logic [5:0]         src_q;
  logic [5:0]         dst_q;
  logic signed [15:0] weight_q;

  // graph state held in flops
  logic [MAX_VERTICES-1:0] vertex_present;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    rd_row_valid;

  // bfs working sets
  logic [MAX_VERTICES-1:0] visited_set;
  logic [MAX_VERTICES-1:0] frontier_set;
  logic [MAX_VERTICES-1:0] next_set;
  logic [LEVEL_BITS-1:0]   level_count;
  logic [VERTEX_BITS-1:0]  scan_idx;
  logic [VERTEX_BITS-1:0]  proc_idx;
  logic                    proc_valid;

  // pending result
  rsp_t res;

  // memory ports
  logic                    adj_we;
  logic [VERTEX_BITS-1:0]  adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic                    wt_we;
  logic [WEIGHT_BITS-1:0]  wt_rdata;

  logic [MAX_VERTICES-1:0] row_data;
  logic [MAX_VERTICES-1:0] dst_bit;
  logic                    edge_hit;
  logic                    ends_ok;
  logic                    accept;
  logic                    out_free;
  logic [LEVEL_BITS-1:0]   level_inc;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // rows never written read as empty
  assign row_data  = rd_row_valid ? adj_rdata : '0;
  assign dst_bit   = MAX_VERTICES'(1) << dst_q;
  assign edge_hit  = row_data[dst_q];
  assign ends_ok   = vertex_present[src_q] && vertex_present[dst_q];
  assign level_inc = level_count + LEVEL_BITS'(1);
  assign adj_wdata = row_data | dst_bit;

  always_comb begin
    unique case (state)
      ST_IDLE:  adj_raddr = req.src_vertex;
      ST_SCAN:  adj_raddr = scan_idx;
      default:  adj_raddr = src_q;
    endcase
  end

  gsbhd_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (src_q),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // weight address is the latched pair, so the read in ST_ROW lands in ST_WREAD
  gsbhd_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (EDGE_DEPTH)
  ) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr ({src_q, dst_q}),
    .wdata (WEIGHT_BITS'(weight_q)),
    .raddr ({src_q, dst_q}),
    .rdata (wt_rdata)
  );

  // next state and memory write strobes
  always_comb begin
    state_next = state;
    adj_we     = 1'b0;
    wt_we      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.cmd) inside
            CMD_ADD_EDGE, CMD_EDGE_Q: state_next = ST_ROW;
            CMD_VERTEX_Q:             state_next = ST_RESP;
            CMD_HOP_Q: begin
              state_next = (req.src_vertex == req.dst_vertex) ? ST_RESP : ST_SCAN;
            end
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROW: begin
        if (cmd_q == CMD_ADD_EDGE) begin
          // first weight for a pair is kept
          if (ends_ok && !edge_hit) begin
            adj_we = 1'b1;
            wt_we  = 1'b1;
          end
          state_next = ST_IDLE;
        end else begin
          state_next = (ends_ok && edge_hit) ? ST_WREAD : ST_RESP;
        end
      end
      ST_WREAD: state_next = ST_RESP;
      ST_SCAN:  state_next = (scan_idx == VERTEX_BITS'(MAX_VERTICES - 1)) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_next = ST_LEVEL;
      ST_LEVEL: begin
        if (next_set[dst_q] || (next_set == '0)) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_RESP:  state_next = out_free ? ST_IDLE : ST_RESP;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the beat and flop the row valid bit alongside the memory read
  always_ff @(posedge clk) begin
    rd_row_valid <= row_valid[adj_raddr];
    if (accept) begin
      cmd_q    <= req.cmd;
      src_q    <= req.src_vertex;
      dst_q    <= req.dst_vertex;
      weight_q <= req.weight_in;
    end
  end

  // vertex set and row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_present <= '0;
      row_valid      <= '0;
    end else begin
      if (accept && (req.cmd == CMD_ADD_VERTEX)) begin
        vertex_present[req.src_vertex] <= 1'b1;
      end
      if (adj_we) begin
        row_valid[src_q] <= 1'b1;
      end
    end
  end

  // bfs walk: one adjacency row read per cycle, processed in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      visited_set  <= '0;
      frontier_set <= '0;
      next_set     <= '0;
      level_count  <= '0;
      scan_idx     <= '0;
      proc_idx     <= '0;
      proc_valid   <= 1'b0;
    end else begin
      proc_valid <= (state == ST_SCAN);
      proc_idx   <= scan_idx;
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + VERTEX_BITS'(1);
      end
      // visited stays fixed for the whole level, as the walk demands
      if (proc_valid && frontier_set[proc_idx]) begin
        next_set <= next_set | (row_data & ~visited_set);
      end
      if (accept && (req.cmd == CMD_HOP_Q)) begin
        visited_set  <= MAX_VERTICES'(1) << req.src_vertex;
        frontier_set <= MAX_VERTICES'(1) << req.src_vertex;
        next_set     <= '0;
        level_count  <= '0;
        scan_idx     <= '0;
      end
      if (state == ST_LEVEL) begin
        level_count  <= level_inc;
        visited_set  <= visited_set | next_set;
        frontier_set <= next_set;
        next_set     <= '0;
        scan_idx     <= '0;
      end
    end
  end

  // build the pending result in whichever state settles it
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.cmd == CMD_VERTEX_Q) begin
        res.found  <= vertex_present[req.src_vertex];
        res.answer <= vertex_present[req.src_vertex] ? 16'sd1 : 16'sd0;
      end else begin
        // hop query with equal ends answers zero hops
        res.found  <= 1'b1;
        res.answer <= 16'sd0;
      end
    end
    if (state == ST_ROW) begin
      res.found  <= 1'b0;
      res.answer <= ANSWER_NONE;
    end
    if (state == ST_WREAD) begin
      res.found  <= 1'b1;
      res.answer <= 16'(signed'(wt_rdata));
    end
    if (state == ST_LEVEL) begin
      if (next_set[dst_q]) begin
        res.found  <= 1'b1;
        res.answer <= 16'(level_inc);
      end else begin
        res.found  <= 1'b0;
        res.answer <= ANSWER_NONE;
      end
    end
  end

  // output register, loaded once the previous beat is gone
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_RESP) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && out_free) begin
      rsp <= res;
    end
  end

endmodule

// ===== hw/rtl/gsbhd_ram.sv =====
module gsbhd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/bfs_graph_checker.sv =====
module bfs_graph_checker
  import gsbhd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  input  logic end_of_test,
  output int   fail_count,
  output int   open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the graph store
  logic [MAX_VERTICES-1:0] known_vertices;
  logic [MAX_VERTICES-1:0] out_edges [MAX_VERTICES];
  logic signed [15:0]      edge_weight_mem [EDGE_DEPTH];

  rsp_t expected_rsps [$];
  rsp_t want;
  int   errs = 0;
  bit   tallied = 0;

  // level-by-level walk, -1 when dst is never reached
  function automatic int hop_levels(input int src, input int dst);
    logic [MAX_VERTICES-1:0] seen;
    logic [MAX_VERTICES-1:0] wave;
    logic [MAX_VERTICES-1:0] reach;
    int level;
    seen = '0;
    seen[src] = 1'b1;
    wave = seen;
    level = 0;
    while (1) begin
      reach = '0;
      for (int u = 0; u < MAX_VERTICES; u++) begin
        if (wave[u]) reach |= out_edges[u];
      end
      reach &= ~seen;
      level++;
      if (reach[dst]) return level;
      if (reach == '0) return -1;
      seen |= reach;
      wave = reach;
    end
  endfunction

  function automatic void predict_command(input req_t item);
    logic s_ok;
    logic d_ok;
    rsp_t res;
    int   h;
    s_ok = known_vertices[item.src_vertex];
    d_ok = known_vertices[item.dst_vertex];
    case (item.cmd)
      CMD_ADD_VERTEX: known_vertices[item.src_vertex] = 1'b1;
      CMD_ADD_EDGE: begin
        if (s_ok && d_ok && !out_edges[item.src_vertex][item.dst_vertex]) begin
          out_edges[item.src_vertex][item.dst_vertex] = 1'b1;
          edge_weight_mem[{item.src_vertex, item.dst_vertex}] = item.weight_in;
        end
      end
      CMD_VERTEX_Q: begin
        res.found  = s_ok;
        res.answer = s_ok ? 16'sd1 : 16'sd0;
        expected_rsps = {expected_rsps, res};
      end
      CMD_EDGE_Q: begin
        if (s_ok && d_ok && out_edges[item.src_vertex][item.dst_vertex]) begin
          res.found  = 1'b1;
          res.answer = edge_weight_mem[{item.src_vertex, item.dst_vertex}];
        end else begin
          res.found  = 1'b0;
          res.answer = ANSWER_NONE;
        end
        expected_rsps = {expected_rsps, res};
      end
      CMD_HOP_Q: begin
        if (item.src_vertex == item.dst_vertex) begin
          res.found  = 1'b1;
          res.answer = 16'sd0;
        end else begin
          h = hop_levels(item.src_vertex, item.dst_vertex);
          res.found  = (h >= 0);
          res.answer = (h >= 0) ? h[15:0] : ANSWER_NONE;
        end
        expected_rsps = {expected_rsps, res};
      end
      default: ;  // spare codes leave no trace
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      known_vertices = '0;
      for (int v = 0; v < MAX_VERTICES; v++) out_edges[v] = '0;
      expected_rsps.delete();
    end else begin
      // response first: it always belongs to an earlier command
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response found %0b answer %0d", $time,
                   rsp.found, rsp.answer);
          errs++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, rsp.found);
            errs++;
          end
          if (rsp.answer !== want.answer) begin
            $display("%0t: answer expected %0d got %0d", $time, want.answer,
                     rsp.answer);
            errs++;
          end
        end
      end
      if (req_valid && req_ready) predict_command(req);
      if (end_of_test && !tallied) begin
        tallied = 1'b1;
        if (expected_rsps.size() != 0) begin
          $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
          errs += expected_rsps.size();
        end
      end
    end
    fail_count <= errs;
    open_count <= expected_rsps.size();
  end

endmodule

// ===== test/tb_graph_store_bfs_hop_distance.sv =====
module tb_graph_store_bfs_hop_distance;
  import gsbhd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the block must ignore
  localparam logic [2:0] CMD_FIRST_SPARE = 3'd5;
  localparam logic [2:0] CMD_LAST_SPARE  = 3'd7;

  localparam int RANDOM_CMDS = 110;
  localparam int POOL_SIZE   = 20;
  localparam int MAX_IDLE    = 16;
  // drain well past the deepest hop walk
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE      = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic end_of_test = 1'b0;
  int   fail_count;
  int   open_count;

  // when set, neither side idles: back-to-back beats
  bit quiet = 1'b0;

  // vertices that most random commands draw from, so chains get long
  logic [5:0] pool [POOL_SIZE];

  initial begin
    forever #5 clk = ~clk;
  end

  graph_store_bfs_hop_distance DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bfs_graph_checker graph_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .end_of_test (end_of_test),
    .fail_count  (fail_count),
    .open_count  (open_count)
  );

  // one command beat; returns at the edge where it is accepted
  task automatic issue(input logic [2:0] code, input logic [5:0] src,
                       input logic [5:0] dst, input logic [15:0] weight);
    req_t item;
    int   gap;
    item.cmd        = cmd_code_t'(code);
    item.src_vertex = src;
    item.dst_vertex = dst;
    item.weight_in  = weight;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    // with no gap valid stays high straight into the next beat
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // mostly the pool, sometimes anywhere in the vertex range
  function automatic logic [5:0] pick_vertex();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, MAX_VERTICES - 1));
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // mostly random weights, now and then the two extremes
  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // response side: random stall before each beat, ready held until it lands
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  initial begin
    int order [MAX_VERTICES];
    int tmp;
    int j;
    int a;
    int b;
    int roll;
    int sent;
    int waited;

    // distinct pool through a shuffle of all vertex numbers
    for (int i = 0; i < MAX_VERTICES; i++) order[i] = i;
    for (int i = MAX_VERTICES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = 6'(order[i]);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // queries on an empty store
    issue(CMD_VERTEX_Q, 0, 0, 0);
    issue(CMD_HOP_Q, 5, 5, 0);          // same vertex, absent: still distance zero
    issue(CMD_HOP_Q, 0, 63, 0);         // absent source
    issue(CMD_ADD_EDGE, 0, 63, 1);      // endpoints absent, dropped
    issue(CMD_ADD_VERTEX, 0, 0, 0);
    issue(CMD_ADD_VERTEX, 63, 0, 0);
    issue(CMD_ADD_VERTEX, 0, 0, 0);     // repeated add
    issue(CMD_EDGE_Q, 0, 63, 0);        // both present, edge absent
    issue(CMD_ADD_EDGE, 0, 63, 16'h8000);
    issue(CMD_ADD_EDGE, 0, 63, 16'h7fff); // duplicate, first weight stays
    issue(CMD_EDGE_Q, 0, 63, 0);
    // small chain 0 -> 63 -> 21 -> 42 with a back edge 42 -> 21
    issue(CMD_ADD_VERTEX, 21, 0, 0);
    issue(CMD_ADD_VERTEX, 42, 0, 0);
    issue(CMD_ADD_EDGE, 63, 21, 16'h7fff);
    issue(CMD_ADD_EDGE, 21, 42, 16'hffff);
    issue(CMD_ADD_EDGE, 42, 21, 16'h0000);
    issue(CMD_HOP_Q, 0, 42, 0);         // three levels
    issue(CMD_HOP_Q, 42, 0, 0);         // cycle, never reaches 0
    issue(CMD_HOP_Q, 7, 21, 0);         // absent source
    issue(CMD_EDGE_Q, 63, 21, 0);
    issue(CMD_VERTEX_Q, 63, 0, 0);
    for (int c = CMD_FIRST_SPARE; c <= CMD_LAST_SPARE; c++) begin
      issue(c[2:0], 63, 63, 16'hffff);
    end
    issue(CMD_ADD_EDGE, 0, 42, 16'h5555); // shortcut
    issue(CMD_HOP_Q, 0, 42, 0);         // now one level

    // ---- random part ----
    // early on more vertex adds, later chain edges along the pool and
    // queries that walk it; a few spare codes as noise
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      if ($urandom_range(0, 24) == 0) quiet = !quiet;
      roll = $urandom_range(0, 99);
      a = $urandom_range(0, POOL_SIZE - 2);
      if (sent < 40 && roll < 35) begin
        issue(CMD_ADD_VERTEX, pool[$urandom_range(0, POOL_SIZE - 1)], pick_vertex(),
              pick_weight());
      end else if (roll < 12) begin
        issue(CMD_ADD_VERTEX, pick_vertex(), pick_vertex(), pick_weight());
      end else if (roll < 40) begin
        if ($urandom_range(0, 1) == 0) begin
          issue(CMD_ADD_EDGE, pool[a], pool[a + 1], pick_weight());
        end else begin
          issue(CMD_ADD_EDGE, pick_vertex(), pick_vertex(), pick_weight());
        end
      end else if (roll < 52) begin
        issue(CMD_VERTEX_Q, pick_vertex(), pick_vertex(), pick_weight());
      end else if (roll < 66) begin
        if ($urandom_range(0, 1) == 0) begin
          issue(CMD_EDGE_Q, pool[a], pool[a + 1], pick_weight());
        end else begin
          issue(CMD_EDGE_Q, pick_vertex(), pick_vertex(), pick_weight());
        end
      end else if (roll < 95) begin
        b = $urandom_range(a + 1, POOL_SIZE - 1);
        case ($urandom_range(0, 9))
          0:       begin
            j = pick_vertex();
            issue(CMD_HOP_Q, 6'(j), 6'(j), pick_weight());
          end
          1, 2, 3: issue(CMD_HOP_Q, pick_vertex(), pick_vertex(), pick_weight());
          4:       issue(CMD_HOP_Q, pool[b], pool[a], pick_weight());  // against the chain
          default: issue(CMD_HOP_Q, pool[a], pool[b], pick_weight());  // along the chain
        endcase
      end else begin
        issue(3'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE)), pick_vertex(),
              pick_vertex(), pick_weight());
        sent--;  // ignored beats do not count
      end
      sent++;
    end
    req_valid <= 1'b0;

    // drain outstanding responses, then let the block settle
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (open_count != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop: far beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
